// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port checker of the median filter.
// No dependencies; each macro expects clk_i and rst_ni in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that is checked at the same clock edge.
`define SWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sliding window median: same-cycle check failed");

// Implication whose consequent is checked at the following clock edge.
`define SWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sliding window median: next-cycle check failed");

`endif

// ----- rtl/swm_pkg.sv -----
// Shared constants and types of the sliding window median filter.
// No dependencies; used by the cell, the chain and the top level.
package swm_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 7;
  localparam int WINDOW_MAX_DEF = 64;

  localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 7'd3;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic step;  // insert a new sample, evict the oldest entry, age the rest
    logic trim;  // remove the lowest entry that is too old for the window
  } swm_cmd_t;

  // Status gathered from the chain.
  typedef struct packed {
    logic drop;   // some cell is removed by the current command
    logic stale;  // some valid entry is older than the window allows
  } swm_status_t;

endpackage

// ----- rtl/swm_cell.sv -----
// One cell of the sorted chain: holds one sample and its age.
// Depends on swm_pkg; instantiated by swm_chain.
module swm_cell #(
  parameter int IDX   = 0,
  parameter int AGE_W = 6,
  parameter int CNT_W = 7
) (
  input  logic                                clk_i,
  input  swm_pkg::swm_cmd_t                   cmd_i,
  input  logic signed [swm_pkg::DATA_W-1:0]   sample_i,
  input  logic        [CNT_W-1:0]             win_len_i,
  input  logic        [CNT_W-1:0]             fill_i,
  // Contents of the cell above.
  input  logic                                up_valid_i,
  input  logic signed [swm_pkg::DATA_W-1:0]   up_value_i,
  input  logic        [AGE_W-1:0]             up_age_i,
  // Post-removal contents of the cell below.
  input  logic signed [swm_pkg::DATA_W-1:0]   dn_value_i,
  input  logic        [AGE_W-1:0]             dn_age_i,
  input  logic                                dn_gt_i,
  input  logic                                hole_i,
  // Own contents, to the cell below and to the median tap.
  output logic                                cur_valid_o,
  output logic signed [swm_pkg::DATA_W-1:0]   cur_value_o,
  output logic        [AGE_W-1:0]             cur_age_o,
  // Post-removal contents, to the cell above.
  output logic signed [swm_pkg::DATA_W-1:0]   rem_value_o,
  output logic        [AGE_W-1:0]             rem_age_o,
  output logic                                gt_o,
  output logic                                hole_o,
  output logic                                stale_o
);
  import swm_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic signed [DATA_W-1:0] value_q, value_d;
  logic        [AGE_W-1:0]  age_q, age_d;
  logic                     cur_valid;
  logic        [CNT_W-1:0]  age_ext;
  logic        [CNT_W-1:0]  age_inc;
  logic                     drop;
  logic                     rem_valid;

  // Valid entries always form the bottom of the chain.
  assign cur_valid   = IDX_C < fill_i;
  assign cur_valid_o = cur_valid;
  assign cur_value_o = value_q;
  assign cur_age_o   = age_q;

  // An entry leaves when its age, after this step, reaches the window length.
  assign age_ext = CNT_W'(age_q);
  assign age_inc = age_ext + CNT_W'(cmd_i.step);
  assign drop    = cur_valid && (age_inc >= win_len_i);
  assign stale_o = cur_valid && (age_ext >= win_len_i);
  assign hole_o  = hole_i | drop;

  // At or above the removed entry, everything moves down by one place.
  assign rem_valid   = hole_o ? up_valid_i : cur_valid;
  assign rem_value_o = hole_o ? up_value_i : value_q;
  assign rem_age_o   = hole_o ? up_age_i   : age_q;

  // Insertion goes after all entries that are not greater than the sample.
  assign gt_o = !rem_valid || (rem_value_o > sample_i);

  // Next contents: insertion shifts the upper part of the chain up by one.
  always_comb begin
    value_d = value_q;
    age_d   = age_q;
    if (cmd_i.step) begin
      if (gt_o) begin
        if (dn_gt_i) begin
          value_d = dn_value_i;
          age_d   = dn_age_i + AGE_W'(1);
        end else begin
          value_d = sample_i;
          age_d   = '0;
        end
      end else begin
        value_d = rem_value_o;
        age_d   = rem_age_o + AGE_W'(1);
      end
    end else if (cmd_i.trim) begin
      value_d = rem_value_o;
      age_d   = rem_age_o;
    end
  end

  // Sample storage.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
  end

endmodule

// ----- rtl/swm_chain.sv -----
// Row of sorted cells with the median tap and the status reductions.
// Depends on swm_pkg and swm_cell; instantiated by sliding_window_median.
module swm_chain #(
  parameter int N     = swm_pkg::WINDOW_MAX_DEF,
  parameter int AGE_W = 6,
  parameter int CNT_W = 7
) (
  input  logic                                clk_i,
  input  swm_pkg::swm_cmd_t                   cmd_i,
  input  logic signed [swm_pkg::DATA_W-1:0]   sample_i,
  input  logic        [CNT_W-1:0]             win_len_i,
  input  logic        [CNT_W-1:0]             fill_i,
  input  logic        [CNT_W-1:0]             med_idx_i,
  output logic signed [swm_pkg::DATA_W-1:0]   median_o,
  output swm_pkg::swm_status_t                status_o
);
  import swm_pkg::*;

  // Index g holds cell g's own contents; index N is the empty slot above.
  logic                     cur_valid [0:N];
  logic signed [DATA_W-1:0] cur_value [0:N];
  logic        [AGE_W-1:0]  cur_age   [0:N];
  // Index g+1 holds cell g's post-removal view; index 0 is the floor.
  logic signed [DATA_W-1:0] rem_value [0:N];
  logic        [AGE_W-1:0]  rem_age   [0:N];
  logic                     gt        [0:N];
  logic                     hole      [0:N];
  logic                     stale     [0:N-1];

  assign cur_valid[N] = 1'b0;
  assign cur_value[N] = '0;
  assign cur_age[N]   = '0;
  assign rem_value[0] = '0;
  assign rem_age[0]   = '0;
  assign gt[0]        = 1'b0;
  assign hole[0]      = 1'b0;

  // The cells, each wired to its two neighbors.
  for (genvar g = 0; g < N; g++) begin : g_cell
    swm_cell #(
      .IDX   (g),
      .AGE_W (AGE_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd_i),
      .sample_i    (sample_i),
      .win_len_i   (win_len_i),
      .fill_i      (fill_i),
      .up_valid_i  (cur_valid[g+1]),
      .up_value_i  (cur_value[g+1]),
      .up_age_i    (cur_age[g+1]),
      .dn_value_i  (rem_value[g]),
      .dn_age_i    (rem_age[g]),
      .dn_gt_i     (gt[g]),
      .hole_i      (hole[g]),
      .cur_valid_o (cur_valid[g]),
      .cur_value_o (cur_value[g]),
      .cur_age_o   (cur_age[g]),
      .rem_value_o (rem_value[g+1]),
      .rem_age_o   (rem_age[g+1]),
      .gt_o        (gt[g+1]),
      .hole_o      (hole[g+1]),
      .stale_o     (stale[g])
    );
  end

  // Median tap and stale flag: AND-OR over the cells; a removal shows at the top.
  always_comb begin
    median_o       = '0;
    status_o.stale = 1'b0;
    status_o.drop  = hole[N];
    for (int i = 0; i < N; i++) begin
      if (med_idx_i == CNT_W'(i)) begin
        median_o = median_o | cur_value[i];
      end
      status_o.stale = status_o.stale | stale[i];
    end
  end

endmodule

// ----- rtl/sliding_window_median.sv -----
// Sliding window median; a result goes via the pending flag to the output register.
// One sample per cycle while in_stall_o is low; the cell chain evicts and inserts in
// one step; after window_len shrinks, trims of stale entries stall the input.
// Reset is asynchronous, active low: window empty, no result pending, window_len 3.
// Cell contents have no reset; only the fill count marks them valid.
module sliding_window_median #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [swm_pkg::CFG_W-1:0]    cfg_window_len_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [swm_pkg::DATA_W-1:0]   sample_i,
  input  logic                                end_of_sequence_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [swm_pkg::DATA_W-1:0]   median_o,
  output logic                                last_median_o
);
  import swm_pkg::*;

  localparam int CNT_W = ($clog2(WINDOW_MAX + 1) > CFG_W) ? $clog2(WINDOW_MAX + 1) : CFG_W;
  localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(WINDOW_MAX);

  logic        [CFG_W-1:0]  win_q;
  logic        [CNT_W-1:0]  win_ext;
  logic        [CNT_W-1:0]  win_len;
  logic        [CNT_W-1:0]  med_idx;
  logic        [CNT_W-1:0]  fill_q, fill_d;
  logic        [CNT_W-1:0]  fill_after;
  logic                     pend_q, pend_d;
  logic                     last_pend_q, last_pend_d;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] median_q;
  logic                     last_q;
  logic signed [DATA_W-1:0] tap;
  logic                     blocked;
  logic                     load;
  logic                     in_acc;
  logic                     produce;
  swm_cmd_t                 cmd;
  swm_status_t              status;

  // Effective window length and the sorted position of the lower median.
  assign win_ext = CNT_W'(win_q);
  assign win_len = (win_ext == '0)   ? CNT_W'(1) :
                   (win_ext > MAX_C) ? MAX_C     : win_ext;
  assign med_idx = (win_len - CNT_W'(1)) >> 1;

  // A pending result waits while the output register is full and stalled.
  assign blocked    = pend_q && out_valid_q && out_stall_i;
  assign load       = pend_q && !blocked;
  assign in_stall_o = status.stale || blocked;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cmd = '{step: in_acc, trim: status.stale && !pend_q};

  swm_chain #(
    .N     (WINDOW_MAX),
    .AGE_W (AGE_W),
    .CNT_W (CNT_W)
  ) u_chain (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .sample_i  (sample_i),
    .win_len_i (win_len),
    .fill_i    (fill_q),
    .med_idx_i (med_idx),
    .median_o  (tap),
    .status_o  (status)
  );

  // Fill count and pending result.
  assign fill_after = fill_q - CNT_W'(status.drop) + CNT_W'(1);
  assign produce    = fill_after == win_len;

  always_comb begin
    fill_d      = fill_q;
    pend_d      = pend_q;
    last_pend_d = last_pend_q;
    if (in_acc) begin
      fill_d      = end_of_sequence_i ? '0 : fill_after;
      pend_d      = produce;
      last_pend_d = end_of_sequence_i;
    end else begin
      if (cmd.trim) begin
        fill_d = fill_q - CNT_W'(status.drop);
      end
      if (load) begin
        pend_d = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WINDOW_LEN_RST;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      last_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        win_q <= cfg_window_len_i;
      end
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      last_pend_q <= last_pend_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload, taken from the chain after the sample has settled in.
  always_ff @(posedge clk_i) begin
    if (load) begin
      median_q <= tap;
      last_q   <= last_pend_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign median_o      = median_q;
  assign last_median_o = last_q;

endmodule

// ----- rtl/swm_checker.sv -----
// Port-level checks of the sliding window median, attached by a bind statement.
// Depends on swm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swm_port_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                end_of_sequence_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [swm_pkg::DATA_W-1:0]   median_o,
  input logic                                last_median_o
);

  // A stalled result transaction stays offered and unchanged.
  `SWM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `SWM_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i,
                   $stable(median_o) && $stable(last_median_o))

  // A fresh result follows an accepted sample through the pending flag and the output register.
  `SWM_ASSERT_NOW(a_out_latency, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2))

  // The last flag of a fresh result is that sample's end-of-sequence flag.
  `SWM_ASSERT_NOW(a_out_last, $rose(out_valid_o), last_median_o == $past(end_of_sequence_i, 2))

endmodule

bind sliding_window_median swm_port_checker u_swm_checker (.*);

// ----- tb/swm_checker.sv -----
// Checker for the sliding window median filter: watches the configuration, sample and
// result channels, predicts each median and compares it with what the block returns.
// Depends on swm_pkg for the data and register widths and the window length at reset.
`timescale 1ns / 100ps

module swm_checker #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic        [swm_pkg::CFG_W-1:0]    cfg_window_len_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [swm_pkg::DATA_W-1:0]   sample_i,
  input  logic                                end_of_sequence_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [swm_pkg::DATA_W-1:0]   median_i,
  input  logic                                last_median_i,
  output int                                  errors_o,
  output int                                  pending_o,
  output int                                  results_o
);

  import swm_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] median;
    logic                     last_median;
  } median_item_t;

  // Medians still owed by the block, oldest first.
  median_item_t expected_medians[$];

  // Shadow copy of the window: values in ascending order, each with its age.
  logic signed [DATA_W-1:0] window_vals [WINDOW_MAX];
  int                       window_ages [WINDOW_MAX];
  int                       window_fill;
  logic [CFG_W-1:0]         window_len;

  int error_count;
  int result_count;

  // Slides one sample into the shadow window and queues the median it yields, if any.
  task automatic slide_window(input logic signed [DATA_W-1:0] smp, input logic eos);
    int           eff_len;
    int           kept;
    int           pos;
    median_item_t item;
    eff_len = (window_len == 0) ? 1 : ((window_len > WINDOW_MAX) ? WINDOW_MAX : window_len);
    // Drop entries that would be too old once the new sample is in.
    kept = 0;
    for (int i = 0; i < window_fill; i++) begin
      if (window_ages[i] + 1 < eff_len) begin
        window_vals[kept] = window_vals[i];
        window_ages[kept] = window_ages[i] + 1;
        kept++;
      end
    end
    window_fill = kept;
    // Insert after every entry that is less than or equal to the sample.
    pos = 0;
    while (pos < window_fill && window_vals[pos] <= smp) pos++;
    for (int i = window_fill; i > pos; i--) begin
      window_vals[i] = window_vals[i-1];
      window_ages[i] = window_ages[i-1];
    end
    window_vals[pos] = smp;
    window_ages[pos] = 0;
    window_fill++;
    if (window_fill == eff_len) begin
      item.median      = window_vals[(eff_len - 1) / 2];
      item.last_median = eos;
      expected_medians.insert(expected_medians.size(), item);
    end
    if (eos) window_fill = 0;
  endtask

  // Compares one returned result with the oldest expected median.
  task automatic check_result();
    median_item_t want;
    result_count++;
    if (expected_medians.size() == 0) begin
      error_count++;
      $error("unexpected result: median %0d, last_median %0b", median_i, last_median_i);
    end else begin
      want = expected_medians[0];
      expected_medians.delete(0);
      if (median_i !== want.median) begin
        error_count++;
        $error("median mismatch: expected %0d, actual %0d", want.median, median_i);
      end
      if (last_median_i !== want.last_median) begin
        error_count++;
        $error("last_median mismatch: expected %0b, actual %0b",
               want.last_median, last_median_i);
      end
    end
  endtask

  // Observe every channel at the clock edge; results are checked before new samples
  // are predicted so a result never matches an expectation queued at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_medians.delete();
      window_fill  = 0;
      window_len   = WINDOW_LEN_RST;
      error_count  = 0;
      result_count = 0;
      errors_o    <= 0;
      pending_o   <= 0;
      results_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (cfg_valid_i && cfg_ready_i) window_len = cfg_window_len_i;
      if (in_valid_i && !in_stall_i) slide_window(sample_i, end_of_sequence_i);
      errors_o  <= error_count;
      pending_o <= expected_medians.size();
      results_o <= result_count;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the median filter testbench: clock, reset, sample and configuration stimulus,
// random stalls on the result side and the verdict. Depends on swm_pkg, the block
// sliding_window_median and the checker swm_checker.
`timescale 1ns / 100ps

module tb_top;

  import swm_pkg::*;

  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
  localparam int RANDOM_SAMPLES = 1350;
  localparam int SETTLE_CYCLES  = 8;

  logic                     clk_i             = 1'b0;
  logic                     rst_ni            = 1'b0;
  logic                     cfg_valid_i       = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_W-1:0]         cfg_window_len_i  = '0;
  logic                     in_valid_i        = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] sample_i          = '0;
  logic                     end_of_sequence_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i       = 1'b0;
  logic signed [DATA_W-1:0] median_o;
  logic                     last_median_o;

  int check_errors;
  int medians_owed;
  int medians_seen;

  logic quiet_mode = 1'b0;
  int   stall_run  = 0;
  int   samples_sent;
  int   window_writes;

  sliding_window_median u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_window_len_i  (cfg_window_len_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .end_of_sequence_i (end_of_sequence_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .median_o          (median_o),
    .last_median_o     (last_median_o)
  );

  swm_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_window_len_i  (cfg_window_len_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .sample_i          (sample_i),
    .end_of_sequence_i (end_of_sequence_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .median_i          (median_o),
    .last_median_i     (last_median_o),
    .errors_o          (check_errors),
    .pending_o         (medians_owed),
    .results_o         (medians_seen)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Gap length: mostly none or short, a few long; none at all in quiet mode.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_mode) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample values: extremes, a narrow band that makes duplicates, and full-range noise.
  function automatic logic signed [DATA_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r) inside
      0: begin
        return S_MIN;
      end
      1: begin
        return S_MAX;
      end
      [2:4]: begin
        return $signed($urandom_range(0, 8)) - 4;
      end
      5: begin
        return $urandom_range(0, 1) ? -1 : 0;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // Window register values, biased toward short windows with the extremes mixed in.
  function automatic logic [CFG_W-1:0] pick_window();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r) inside
      0: begin
        return '0;
      end
      1: begin
        return CFG_W'(64);
      end
      2: begin
        return CFG_W'($urandom_range(65, 127));
      end
      3: begin
        return CFG_W'($urandom_range(10, 63));
      end
      [4:5]: begin
        return CFG_W'($urandom_range(1, 2));
      end
      default: begin
        return CFG_W'($urandom_range(3, 9));
      end
    endcase
  endfunction

  // Result side stalls in random runs.
  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      stall_run   <= stall_run - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (!quiet_mode && $urandom_range(0, 3) == 0) stall_run <= pick_gap();
    end
  end

  // Offers one sample and holds it until the block takes it, then idles for a random gap.
  task automatic send_sample(input logic signed [DATA_W-1:0] smp, input logic eos);
    int gap;
    in_valid_i        <= 1'b1;
    sample_i          <= smp;
    end_of_sequence_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    samples_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every expected median has come back.
  task automatic drain_medians();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (medians_owed != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the window length; only called while the block is idle.
  task automatic write_window(input logic [CFG_W-1:0] len);
    cfg_valid_i      <= 1'b1;
    cfg_window_len_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    window_writes++;
  endtask

  // Stimulus and verdict.
  initial begin
    int                   random_sent;
    int                   eff_len;
    int                   phase_target;
    int                   phase_sent;
    int                   seq_len;
    logic [CFG_W-1:0]     len;
    samples_sent  = 0;
    window_writes = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Window of 3 from reset: extremes, then a short sequence that ends with no result.
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b1);
    send_sample(5, 1'b0);
    send_sample(6, 1'b1);
    drain_medians();

    // Window of 1 passes samples through.
    write_window(CFG_W'(1));
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b1);
    send_sample(42, 1'b0);
    drain_medians();

    // Window of 2 gives the smaller of the pair, equal samples included.
    write_window(CFG_W'(2));
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(-3, 1'b0);
    send_sample(S_MAX, 1'b1);
    drain_medians();

    // A zero length acts as a window of 1.
    write_window('0);
    send_sample(-5, 1'b1);
    send_sample(9, 1'b0);
    drain_medians();

    // Shrink the window mid-stream without clearing it.
    write_window(CFG_W'(5));
    for (int i = 1; i <= 5; i++) send_sample(i, 1'b0);
    drain_medians();
    write_window(CFG_W'(2));
    send_sample(0, 1'b0);
    send_sample(10, 1'b1);
    drain_medians();

    // Largest register value acts as the full window; too few samples for a result.
    write_window(CFG_W'(127));
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(1, 1'b1);
    drain_medians();

    // Random phases: one window setting each, sequences of random length.
    random_sent = 0;
    while (random_sent < RANDOM_SAMPLES) begin
      len     = pick_window();
      eff_len = (len == 0) ? 1 : ((len > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : len);
      quiet_mode <= ($urandom_range(0, 3) == 0);
      write_window(len);
      phase_target = $urandom_range(30, 90) + 2 * eff_len;
      phase_sent   = 0;
      while (phase_sent < phase_target) begin
        if ($urandom_range(0, 6) == 0) seq_len = $urandom_range(1, eff_len);
        else seq_len = $urandom_range(eff_len, eff_len + 30);
        for (int i = 0; i < seq_len; i++) begin
          // The last sequence of a phase sometimes stays open across the next write.
          send_sample(pick_sample(),
                      (i == seq_len - 1) &&
                      (phase_sent + 1 < phase_target || $urandom_range(0, 2) != 0));
          phase_sent++;
        end
      end
      random_sent += phase_sent;
      drain_medians();
    end

    quiet_mode <= 1'b0;
    drain_medians();
    $display("Covered %0d samples and %0d returned medians over %0d window writes.",
             samples_sent, medians_seen, window_writes);
    if (check_errors == 0 && medians_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("Timed out waiting on the block.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_chain.sv
rtl/sliding_window_median.sv
rtl/swm_checker.sv
tb/swm_checker.sv
tb/tb_top.sv
